// ----- hw/rtl/sha512_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 package
// Shared types, the initial hash value, the round constants and the
// sigma functions of the SHA-512 compression.
// ----------------------------------------------------------------------------
package sha512_pkg;

  localparam int WORD_W   = 64;
  localparam int ROUNDS   = 80;
  localparam int ROUND_W  = 7;
  localparam int FILL_W   = 7;
  localparam int LEN_STOP = 112;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [7:0][WORD_W-1:0] hash_t;
  typedef logic [15:0][WORD_W-1:0] block_t;

  typedef struct packed {
    logic start;
    logic reload;
  } core_ctl_t;

  typedef struct packed {
    logic busy;
  } core_sts_t;

  localparam hash_t INIT_HASH = {
    64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b, 64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
    64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b, 64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
  };

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

  function automatic word_t round_k(input logic [ROUND_W-1:0] t);
    case (t)
      7'd0:  round_k = 64'h428a2f98d728ae22;
      7'd1:  round_k = 64'h7137449123ef65cd;
      7'd2:  round_k = 64'hb5c0fbcfec4d3b2f;
      7'd3:  round_k = 64'he9b5dba58189dbbc;
      7'd4:  round_k = 64'h3956c25bf348b538;
      7'd5:  round_k = 64'h59f111f1b605d019;
      7'd6:  round_k = 64'h923f82a4af194f9b;
      7'd7:  round_k = 64'hab1c5ed5da6d8118;
      7'd8:  round_k = 64'hd807aa98a3030242;
      7'd9:  round_k = 64'h12835b0145706fbe;
      7'd10: round_k = 64'h243185be4ee4b28c;
      7'd11: round_k = 64'h550c7dc3d5ffb4e2;
      7'd12: round_k = 64'h72be5d74f27b896f;
      7'd13: round_k = 64'h80deb1fe3b1696b1;
      7'd14: round_k = 64'h9bdc06a725c71235;
      7'd15: round_k = 64'hc19bf174cf692694;
      7'd16: round_k = 64'he49b69c19ef14ad2;
      7'd17: round_k = 64'hefbe4786384f25e3;
      7'd18: round_k = 64'h0fc19dc68b8cd5b5;
      7'd19: round_k = 64'h240ca1cc77ac9c65;
      7'd20: round_k = 64'h2de92c6f592b0275;
      7'd21: round_k = 64'h4a7484aa6ea6e483;
      7'd22: round_k = 64'h5cb0a9dcbd41fbd4;
      7'd23: round_k = 64'h76f988da831153b5;
      7'd24: round_k = 64'h983e5152ee66dfab;
      7'd25: round_k = 64'ha831c66d2db43210;
      7'd26: round_k = 64'hb00327c898fb213f;
      7'd27: round_k = 64'hbf597fc7beef0ee4;
      7'd28: round_k = 64'hc6e00bf33da88fc2;
      7'd29: round_k = 64'hd5a79147930aa725;
      7'd30: round_k = 64'h06ca6351e003826f;
      7'd31: round_k = 64'h142929670a0e6e70;
      7'd32: round_k = 64'h27b70a8546d22ffc;
      7'd33: round_k = 64'h2e1b21385c26c926;
      7'd34: round_k = 64'h4d2c6dfc5ac42aed;
      7'd35: round_k = 64'h53380d139d95b3df;
      7'd36: round_k = 64'h650a73548baf63de;
      7'd37: round_k = 64'h766a0abb3c77b2a8;
      7'd38: round_k = 64'h81c2c92e47edaee6;
      7'd39: round_k = 64'h92722c851482353b;
      7'd40: round_k = 64'ha2bfe8a14cf10364;
      7'd41: round_k = 64'ha81a664bbc423001;
      7'd42: round_k = 64'hc24b8b70d0f89791;
      7'd43: round_k = 64'hc76c51a30654be30;
      7'd44: round_k = 64'hd192e819d6ef5218;
      7'd45: round_k = 64'hd69906245565a910;
      7'd46: round_k = 64'hf40e35855771202a;
      7'd47: round_k = 64'h106aa07032bbd1b8;
      7'd48: round_k = 64'h19a4c116b8d2d0c8;
      7'd49: round_k = 64'h1e376c085141ab53;
      7'd50: round_k = 64'h2748774cdf8eeb99;
      7'd51: round_k = 64'h34b0bcb5e19b48a8;
      7'd52: round_k = 64'h391c0cb3c5c95a63;
      7'd53: round_k = 64'h4ed8aa4ae3418acb;
      7'd54: round_k = 64'h5b9cca4f7763e373;
      7'd55: round_k = 64'h682e6ff3d6b2b8a3;
      7'd56: round_k = 64'h748f82ee5defb2fc;
      7'd57: round_k = 64'h78a5636f43172f60;
      7'd58: round_k = 64'h84c87814a1f0ab72;
      7'd59: round_k = 64'h8cc702081a6439ec;
      7'd60: round_k = 64'h90befffa23631e28;
      7'd61: round_k = 64'ha4506cebde82bde9;
      7'd62: round_k = 64'hbef9a3f7b2c67915;
      7'd63: round_k = 64'hc67178f2e372532b;
      7'd64: round_k = 64'hca273eceea26619c;
      7'd65: round_k = 64'hd186b8c721c0c207;
      7'd66: round_k = 64'heada7dd6cde0eb1e;
      7'd67: round_k = 64'hf57d4f7fee6ed178;
      7'd68: round_k = 64'h06f067aa72176fba;
      7'd69: round_k = 64'h0a637dc5a2c898a6;
      7'd70: round_k = 64'h113f9804bef90dae;
      7'd71: round_k = 64'h1b710b35131c471b;
      7'd72: round_k = 64'h28db77f523047d84;
      7'd73: round_k = 64'h32caab7b40c72493;
      7'd74: round_k = 64'h3c9ebe0a15c9bebc;
      7'd75: round_k = 64'h431d67c49c100d4c;
      7'd76: round_k = 64'h4cc5d4becb3e42b6;
      7'd77: round_k = 64'h597f299cfc657e2a;
      7'd78: round_k = 64'h5fcb6fab3ad6faec;
      7'd79: round_k = 64'h6c44198c4a475817;
      default: round_k = '0;
    endcase
  endfunction

endpackage

// ----- hw/rtl/sha512_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 compression core
// One round unit used for all 80 rounds, a 16-word schedule shift line and
// the chaining value, with a final state that adds the working variables.
// ----------------------------------------------------------------------------
module sha512_core (
  input  logic                   clk,
  input  logic                   rst,
  input  sha512_pkg::core_ctl_t  ctl,
  input  sha512_pkg::word_t      block_word,
  output logic [3:0]             block_index,
  output sha512_pkg::core_sts_t  sts,
  output sha512_pkg::hash_t      chain
);
  import sha512_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;

  logic [1:0]         state;
  logic [ROUND_W-1:0] round;
  hash_t              vars;
  block_t             sched;
  word_t              w, t1, t2;

  assign block_index = round[3:0];
  assign sts.busy    = (state != ST_IDLE);

  // Message schedule taps sit at fixed places of the shift line.
  always_comb begin
    if (round < ROUND_W'(16)) begin
      w = block_word;
    end else begin
      w = ssig1(sched[14]) + sched[9] + ssig0(sched[1]) + sched[0];
    end
    t1 = vars[7] + bsig1(vars[4]) + ((vars[4] & vars[5]) ^ (~vars[4] & vars[6]))
       + round_k(round) + w;
    t2 = bsig0(vars[0]) + ((vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      round <= '0;
      chain <= INIT_HASH;
    end else begin
      case (state)
        ST_IDLE: begin
          if (ctl.reload) begin
            chain <= INIT_HASH;
          end else if (ctl.start) begin
            vars  <= chain;
            round <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          vars  <= {vars[6], vars[5], vars[4], vars[3] + t1,
                    vars[2], vars[1], vars[0], t1 + t2};
          sched <= {w, sched[15:1]};
          if (round == ROUND_W'(ROUNDS - 1)) begin
            round <= '0;
            state <= ST_ADD;
          end else begin
            round <= round + 1'b1;
          end
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + vars[i];
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/sha512_hash_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 hash engine
// Gathers message bytes into 128-byte blocks, pads the final block and
// returns the eight digest words of each message.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Payload
//  input     in_valid / in_stall     message_word, byte_count, end_of_message
//  output    out_valid / out_stall   digest_word, word_number, last_digest_word
//
// A request places its valid bytes into the block one at a time. Every full
// block then runs through the 80 rounds of the shared round unit and the
// chaining addition. The final request adds the padding, one byte per cycle
// while no block is compressed, up to the length field, then the length
// field and eight digest words. Reset is synchronous and restores the
// initial hash value and clears the counters. The input is stalled for the
// whole of this work, and a stalled digest word holds until it is taken.
// ----------------------------------------------------------------------------
module sha512_hash_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  sha512_pkg::word_t         message_word,
  input  logic [3:0]                byte_count,
  input  logic                      end_of_message,
  output logic                      out_valid,
  input  logic                      out_stall,
  output sha512_pkg::word_t         digest_word,
  output logic [2:0]                word_number,
  output logic                      last_digest_word
);
  import sha512_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BYTES = 3'd1;
  localparam logic [2:0] ST_PAD80 = 3'd2;
  localparam logic [2:0] ST_PADZ  = 3'd3;
  localparam logic [2:0] ST_LEN   = 3'd4;
  localparam logic [2:0] ST_WAIT  = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]        state, ret_state;
  logic [FILL_W-1:0] fill;
  logic [127:0]      bit_len;
  word_t             shift_word;
  logic [3:0]        bytes_left;
  logic              eom;
  logic [2:0]        out_cnt;
  block_t            blk;

  core_ctl_t ctl;
  core_sts_t sts;
  hash_t     chain;
  logic [3:0] blk_index;

  logic       put;
  logic [7:0] put_byte;
  logic [2:0] put_next;
  logic [3:0] count_sat;

  assign count_sat = (byte_count > 4'd8) ? 4'd8 : byte_count;

  // Unless the core is busy, one byte is written per cycle at the fill position;
  // the sequencer's return state after a block compression is chosen alongside.
  always_comb begin
    put      = 1'b0;
    put_byte = 8'h00;
    put_next = state;
    case (state)
      ST_BYTES: begin
        if (bytes_left != 4'd0) begin
          put      = 1'b1;
          put_byte = shift_word[63:56];
          put_next = ST_BYTES;
        end
      end
      ST_PAD80: begin
        put      = 1'b1;
        put_byte = 8'h80;
        put_next = ST_PADZ;
      end
      ST_PADZ: begin
        if (fill != FILL_W'(LEN_STOP)) begin
          put      = 1'b1;
          put_next = ST_PADZ;
        end
      end
      default: put = 1'b0;
    endcase
  end

  assign ctl.start  = (put && (fill == '1)) || (state == ST_LEN);
  assign ctl.reload = (state == ST_DONE);

  sha512_core u_core (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .block_word  (blk[blk_index]),
    .block_index (blk_index),
    .sts         (sts),
    .chain       (chain)
  );

  assign in_stall         = (state != ST_IDLE);
  assign out_valid        = (state == ST_OUT);
  assign digest_word      = chain[out_cnt];
  assign word_number      = out_cnt;
  assign last_digest_word = (out_cnt == 3'd7);

  // The block store has no reset: every byte is written before it is read.
  always_ff @(posedge clk) begin
    if (put) begin
      blk[fill[6:3]][(3'd7 - fill[2:0]) * 8 +: 8] <= put_byte;
    end else if (state == ST_LEN) begin
      blk[14] <= bit_len[127:64];
      blk[15] <= bit_len[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_IDLE;
      fill      <= '0;
      bit_len   <= '0;
      out_cnt   <= '0;
      bytes_left <= '0;
      eom       <= 1'b0;
    end else begin
      if (put) begin
        fill <= fill + 1'b1;
        if (fill == '1) begin
          ret_state <= put_next;
          state     <= ST_WAIT;
        end
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            shift_word <= message_word;
            bytes_left <= count_sat;
            eom        <= end_of_message;
            bit_len    <= bit_len + {121'd0, count_sat, 3'd0};
            state      <= ST_BYTES;
          end
        end
        ST_BYTES: begin
          if (bytes_left != 4'd0) begin
            shift_word <= shift_word << 8;
            bytes_left <= bytes_left - 1'b1;
          end else begin
            state <= eom ? ST_PAD80 : ST_IDLE;
          end
        end
        ST_PAD80: begin
          if (fill != '1) begin
            state <= ST_PADZ;
          end
        end
        ST_PADZ: begin
          if (fill == FILL_W'(LEN_STOP)) begin
            state <= ST_LEN;
          end
        end
        ST_LEN: begin
          ret_state <= ST_OUT;
          state     <= ST_WAIT;
        end
        ST_WAIT: begin
          if (!sts.busy) begin
            state <= ret_state;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_cnt <= out_cnt + 1'b1;
            if (out_cnt == 3'd7) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          fill    <= '0;
          bit_len <= '0;
          state   <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/sha512_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 port checker
// Watches the ports of the hash engine over time.
// ----------------------------------------------------------------------------
module sha512_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] digest_word,
  input logic [2:0]  word_number,
  input logic        last_digest_word
);

  // No new message is taken while a digest is being returned.
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted during digest output");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_digest_word == (word_number == 3'd7)))
    else $error("last flag does not match word number");

  a_word_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_digest_word) |=>
      (out_valid && word_number == $past(word_number) + 3'd1))
    else $error("digest words out of order");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(digest_word)))
    else $error("stalled digest word changed");

endmodule

bind sha512_hash_engine sha512_checker u_checker (
  .clk              (clk),
  .rst              (rst),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .digest_word      (digest_word),
  .word_number      (word_number),
  .last_digest_word (last_digest_word)
);
